/* rtl/core/kcgt_pkg.sv */
// Package: field widths, register map and item structs of the component goal tracker.
`default_nettype none

package kcgt_pkg;

  localparam int ID_W     = 10;
  localparam int WEIGHT_W = 32;
  localparam int SIZE_W   = 11;
  localparam int GOAL_W   = 11;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index is paddr[2]
  localparam logic REG_GOAL_SIZE = 1'b0;

  localparam logic [GOAL_W-1:0] GOAL_RESET = GOAL_W'(1);

  typedef struct packed {
    logic [ID_W-1:0]     node_a;
    logic [ID_W-1:0]     node_b;
    logic [WEIGHT_W-1:0] weight;
  } in_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   merged_size;
    logic                already_joined;
    logic                goal_hit;
    logic [WEIGHT_W-1:0] edge_weight;
  } out_t;

endpackage

`default_nettype wire

/* rtl/core/kcgt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module kcgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/kruskal_component_goal_tracker.sv */
// Top level: union-find edge engine with component sizes and a one-time goal flag.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  in_     | in  | in_valid/in_ready | kcgt_pkg::in_t  (node_a, node_b, weight)
//  out_    | out | out_valid/out_ready | kcgt_pkg::out_t (size, joined, hit, w)
//  cfg_    | in  | APB, pready high  | goal_size at byte address 0
//
// Order of work: S_WRAP folds both ids into range (skipped when the number of id wrap
// steps is 0, at NODE_COUNT >= 1024), S_LOAD starts node_a, S_FIND walks the parent
// links to each root and S_COMP rewrites every link walked by path compression, first
// for node_a and then for node_b; S_MERGE, S_SZA, S_SZB and S_DONE then register the
// result, and the block returns to S_IDLE to take the next item. The single read port
// of the parent RAM sets the pace: one parent link is followed per cycle.
// After reset the block sweeps every entry of both tables (parent = own id,
// size = 1) and holds in_ready low meanwhile; configuration writes are taken.
// One item is in work at a time. A finished item waits in the output register; the
// next item is accepted meanwhile and stalls only at its own result until out_ready.
`default_nettype none

module kruskal_component_goal_tracker #(
  parameter int NODE_COUNT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire kcgt_pkg::in_t                   in_data,

  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output kcgt_pkg::out_t                       out_data,

  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [kcgt_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [kcgt_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic      [kcgt_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);

  // Number of restoring compare/subtract steps that fold a 10-bit id into range.
  function automatic int wrap_steps(input int n);
    int s;
    s = 0;
    for (int k = 0; k < kcgt_pkg::ID_W; k++) begin
      if ((longint'(n) << k) <= longint'((1 << kcgt_pkg::ID_W) - 1)) begin
        s++;
      end
    end
    return s;
  endfunction

  localparam int NW = $clog2(NODE_COUNT);
  localparam int SW = $clog2(NODE_COUNT + 1);
  localparam int XW = (NW > kcgt_pkg::ID_W) ? NW : kcgt_pkg::ID_W;
  localparam int CW = (SW > kcgt_pkg::GOAL_W) ? SW : kcgt_pkg::GOAL_W;
  localparam int WRAP_STEPS = wrap_steps(NODE_COUNT);
  localparam int WRAP_LAST  = (WRAP_STEPS > 0) ? WRAP_STEPS - 1 : 0;
  localparam int KW = 4;
  localparam logic [kcgt_pkg::ID_W-1:0] WRAP_BASE = kcgt_pkg::ID_W'(NODE_COUNT);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODE_COUNT - 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WRAP  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_COMP  = 4'd5;
  localparam logic [3:0] S_MERGE = 4'd6;
  localparam logic [3:0] S_SZA   = 4'd7;
  localparam logic [3:0] S_SZB   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                      state_r, state_nxt;
  logic [NW-1:0]                   clr_cnt_r, clr_cnt_nxt;
  logic [kcgt_pkg::ID_W-1:0]       xa_r, xa_nxt, xb_r, xb_nxt;
  logic [KW-1:0]                   kcnt_r, kcnt_nxt;
  logic [NW-1:0]                   na_r, na_nxt, nb_r, nb_nxt;
  logic [NW-1:0]                   cur_r, cur_nxt;
  logic [NW-1:0]                   root_r, root_nxt;
  logic [NW-1:0]                   comp_r, comp_nxt;
  logic [NW-1:0]                   ra_r, ra_nxt;
  logic                            sel_b_r, sel_b_nxt;
  logic                            joined_r, joined_nxt;
  logic [SW-1:0]                   sa_r, sa_nxt;
  logic [SW-1:0]                   size_r, size_nxt;
  logic [kcgt_pkg::WEIGHT_W-1:0]   w_r, w_nxt;
  logic [kcgt_pkg::GOAL_W-1:0]     goal_r, goal_nxt;
  logic                            goal_done_r, goal_done_nxt;
  logic                            out_valid_r, out_valid_nxt;
  kcgt_pkg::out_t                  out_r, out_nxt;

  // RAM ports
  logic          p_we, s_we;
  logic [NW-1:0] p_waddr, p_raddr, s_waddr, s_raddr;
  logic [NW-1:0] p_wdata, p_rdata;
  logic [SW-1:0] s_wdata, s_rdata;

  // helpers
  logic [kcgt_pkg::ID_W-1:0] cand;
  logic [XW-1:0]             xa_ext, xb_ext;
  logic [NW-1:0]             start_node;
  logic                      ep_done;
  logic [NW-1:0]             ep_root;
  logic [SW-1:0]             sum;
  logic [CW-1:0]             size_cmp, goal_cmp;
  logic                      hit;
  logic                      cfg_wr;

  kcgt_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_parent_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  kcgt_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_size_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign cand       = WRAP_BASE << kcnt_r;
  assign xa_ext     = XW'(xa_r);
  assign xb_ext     = XW'(xb_r);
  assign start_node = sel_b_r ? nb_r : na_r;
  assign sum        = sa_r + s_rdata;
  assign size_cmp   = CW'(size_r);
  assign goal_cmp   = CW'(goal_r);
  assign hit        = !goal_done_r && (size_cmp >= goal_cmp);

  // config port: single register, written in the APB access phase
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == kcgt_pkg::REG_GOAL_SIZE);
  assign goal_nxt   = cfg_wr ? cfg_pwdata[kcgt_pkg::GOAL_W-1:0] : goal_r;
  assign cfg_prdata = (cfg_paddr[2] == kcgt_pkg::REG_GOAL_SIZE) ?
                      kcgt_pkg::CFG_DW'(goal_r) : '0;
  assign cfg_pready = 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    xa_nxt        = xa_r;
    xb_nxt        = xb_r;
    kcnt_nxt      = kcnt_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    comp_nxt      = comp_r;
    ra_nxt        = ra_r;
    sel_b_nxt     = sel_b_r;
    joined_nxt    = joined_r;
    sa_nxt        = sa_r;
    size_nxt      = size_r;
    w_nxt         = w_r;
    goal_done_nxt = goal_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    p_we    = 1'b0;
    p_waddr = cur_r;
    p_wdata = root_r;
    p_raddr = cur_r;
    s_we    = 1'b0;
    s_waddr = ra_r;
    s_wdata = sum;
    s_raddr = ra_r;

    ep_done = 1'b0;
    ep_root = root_r;

    case (state_r)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_cnt_r;
        p_wdata = clr_cnt_r;
        s_we    = 1'b1;
        s_waddr = clr_cnt_r;
        s_wdata = SW'(1);
        if (clr_cnt_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + NW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          xa_nxt    = in_data.node_a;
          xb_nxt    = in_data.node_b;
          w_nxt     = in_data.weight;
          kcnt_nxt  = KW'(WRAP_LAST);
          state_nxt = (WRAP_STEPS > 0) ? S_WRAP : S_LOAD;
        end
      end

      // restoring reduction of both ids modulo NODE_COUNT
      S_WRAP: begin
        if (xa_r >= cand) begin
          xa_nxt = xa_r - cand;
        end
        if (xb_r >= cand) begin
          xb_nxt = xb_r - cand;
        end
        if (kcnt_r == '0) begin
          state_nxt = S_LOAD;
        end else begin
          kcnt_nxt = kcnt_r - KW'(1);
        end
      end

      S_LOAD: begin
        na_nxt    = xa_ext[NW-1:0];
        nb_nxt    = xb_ext[NW-1:0];
        cur_nxt   = xa_ext[NW-1:0];
        p_raddr   = xa_ext[NW-1:0];
        sel_b_nxt = 1'b0;
        state_nxt = S_FIND;
      end

      // one parent link per cycle until a self-parented node shows up
      S_FIND: begin
        if (p_rdata == cur_r) begin
          root_nxt = cur_r;
          if (start_node == cur_r) begin
            ep_done = 1'b1;
            ep_root = cur_r;
          end else begin
            comp_nxt  = start_node;
            p_raddr   = start_node;
            state_nxt = S_COMP;
          end
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end

      // path compression: point each node on the chain straight at the root
      S_COMP: begin
        p_we    = 1'b1;
        p_waddr = comp_r;
        p_wdata = root_r;
        if (p_rdata == root_r) begin
          ep_done = 1'b1;
          ep_root = root_r;
        end else begin
          comp_nxt = p_rdata;
          p_raddr  = p_rdata;
        end
      end

      S_MERGE: begin
        joined_nxt = (ra_r == root_r);
        if (ra_r != root_r) begin
          p_we    = 1'b1;
          p_waddr = root_r;
          p_wdata = ra_r;
        end
        s_raddr   = ra_r;
        state_nxt = S_SZA;
      end

      S_SZA: begin
        sa_nxt    = s_rdata;
        s_raddr   = root_r;
        state_nxt = S_SZB;
      end

      S_SZB: begin
        if (!joined_r) begin
          s_we    = 1'b1;
          s_waddr = ra_r;
          s_wdata = sum;
        end
        size_nxt  = joined_r ? sa_r : sum;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.merged_size    = size_cmp[kcgt_pkg::SIZE_W-1:0];
          out_nxt.already_joined = joined_r;
          out_nxt.goal_hit       = hit;
          out_nxt.edge_weight    = w_r;
          out_valid_nxt          = 1'b1;
          goal_done_nxt          = goal_done_r || hit;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // endpoint finished: move from node_a to node_b, or on to the merge
    if (ep_done) begin
      if (!sel_b_r) begin
        ra_nxt    = ep_root;
        sel_b_nxt = 1'b1;
        cur_nxt   = nb_r;
        p_raddr   = nb_r;
        state_nxt = S_FIND;
      end else begin
        root_nxt  = ep_root;
        state_nxt = S_MERGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      goal_r      <= kcgt_pkg::GOAL_RESET;
      goal_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      goal_r      <= goal_nxt;
      goal_done_r <= goal_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xa_r     <= xa_nxt;
    xb_r     <= xb_nxt;
    kcnt_r   <= kcnt_nxt;
    na_r     <= na_nxt;
    nb_r     <= nb_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    comp_r   <= comp_nxt;
    ra_r     <= ra_nxt;
    sel_b_r  <= sel_b_nxt;
    joined_r <= joined_nxt;
    sa_r     <= sa_nxt;
    size_r   <= size_nxt;
    w_r      <= w_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/kcgt_checker.sv */
// Port-level checker for the component goal tracker, with its bind.
`default_nettype none

module kcgt_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire kcgt_pkg::out_t out_data
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;
  logic       hit_seen_r, hit_seen_nxt;

  assign in_acc       = in_valid && in_ready;
  assign out_acc      = out_valid && out_ready;
  assign pend_nxt     = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  assign hit_seen_nxt = hit_seen_r || (out_acc && out_data.goal_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      hit_seen_r <= 1'b0;
    end else begin
      pend_r     <= pend_nxt;
      hit_seen_r <= hit_seen_nxt;
    end
  end

  // one item in work: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // at most one item in work plus one result waiting
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (pend_r <= 2'd1))
    else $error("item accepted with two items outstanding");

  // goal flag fires at most once per reset
  a_goal_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.goal_hit) |-> !hit_seen_r)
    else $error("goal_hit raised a second time");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind kruskal_component_goal_tracker kcgt_checker u_kcgt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the union-find component goal tracker: directed and random edges, live checks.
module tb_top;
  import kcgt_pkg::*;

  localparam int NODES = 1024;
  localparam int MAX_GAP = 18;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_AW-1:0] GOAL_ADDR = {REG_GOAL_SIZE, 2'b00};
  // no register decodes here; writes must be dropped
  localparam logic [CFG_AW-1:0] SPARE_ADDR = {~REG_GOAL_SIZE, 2'b00};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  kruskal_component_goal_tracker #(.NODE_COUNT(NODES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Forest mirror: parent links, full-width sizes (only roots matter), one-shot goal flag.
  logic [ID_W-1:0] forest_parent [NODES];
  int unsigned forest_size [NODES];
  bit goal_reached;
  logic [GOAL_W-1:0] goal_cfg;

  out_t pending_results[$];
  int miss_count;
  logic [WEIGHT_W-1:0] weight_now;
  bit sender_calm;
  bit receiver_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1_500_000);
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic [ID_W-1:0] root_of(input logic [ID_W-1:0] node);
    logic [ID_W-1:0] top;
    logic [ID_W-1:0] nxt;
    top = node;
    while (forest_parent[top] != top) top = forest_parent[top];
    // path compression: every node on the walk now points at the root
    while (node != top) begin
      nxt = forest_parent[node];
      forest_parent[node] = top;
      node = nxt;
    end
    return top;
  endfunction

  // Applies one edge to the mirror and returns the result the block must give.
  function automatic out_t track_edge(input in_t edge_item);
    logic [ID_W-1:0] ra;
    logic [ID_W-1:0] rb;
    out_t res;
    ra = root_of(edge_item.node_a);
    rb = root_of(edge_item.node_b);
    res.already_joined = (ra == rb);
    if (ra != rb) begin
      forest_parent[rb] = ra;
      forest_size[ra] += forest_size[rb];
    end
    res.merged_size = forest_size[ra][SIZE_W-1:0];
    res.goal_hit = 1'b0;
    if (!goal_reached && forest_size[ra] >= int'(goal_cfg)) begin
      res.goal_hit = 1'b1;
      goal_reached = 1'b1;
    end
    res.edge_weight = edge_item.weight;
    return res;
  endfunction

  // Weights climb and saturate at all ones; about one in eight repeats the last one.
  function automatic logic [WEIGHT_W-1:0] next_weight();
    logic [WEIGHT_W:0] sum;
    if ($urandom_range(0, 7) != 0) begin
      sum = {1'b0, weight_now} + (WEIGHT_W+1)'($urandom_range(0, 1 << 23));
      weight_now = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
    end
    return weight_now;
  endfunction

  task automatic send_edge(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                           input logic [WEIGHT_W-1:0] w);
    int gap;
    in_t item;
    gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.node_a = a;
    item.node_b = b;
    item.weight = w;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), track_edge(item));
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Setup phase, access phase until pready, then an idle bus before the next transfer.
  task automatic cfg_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rd);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_goal(input logic [GOAL_W-1:0] goal);
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b1, GOAL_ADDR, CFG_DW'(goal), rd);
    goal_cfg = goal;
    cfg_access(1'b0, GOAL_ADDR, '0, rd);
    if (rd !== CFG_DW'(goal_cfg)) begin
      miss_count++;
      if (miss_count <= MAX_REPORTS)
        $display("goal readback: expected %0d got %0d", goal_cfg, rd);
    end
  endtask

  // Result side: random stalls on out_ready, each accepted item checked in order.
  initial begin
    int hold;
    out_t want;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          miss_count++;
          if (miss_count <= MAX_REPORTS)
            $display("unexpected item: size=%0d joined=%0d hit=%0d w=%h",
                     out_data.merged_size, out_data.already_joined,
                     out_data.goal_hit, out_data.edge_weight);
        end else begin
          want = pending_results.pop_front();
          if (out_data.merged_size !== want.merged_size ||
              out_data.already_joined !== want.already_joined ||
              out_data.goal_hit !== want.goal_hit ||
              out_data.edge_weight !== want.edge_weight) begin
            miss_count++;
            // fields: size/joined/hit/weight
            if (miss_count <= MAX_REPORTS)
              $display("mismatch: exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                       want.merged_size, want.already_joined, want.goal_hit,
                       want.edge_weight, out_data.merged_size,
                       out_data.already_joined, out_data.goal_hit,
                       out_data.edge_weight);
          end
        end
        hold = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (hold > 0) begin
        hold--;
      end
      out_ready <= (hold == 0);
    end
  end

  // Goal at its top value, then a write to an undecoded address that must not land.
  task automatic test_config_extremes();
    logic [CFG_DW-1:0] rd;
    set_goal('1);
    cfg_access(1'b1, SPARE_ADDR, '0, rd);
  endtask

  // Id extremes, self edges, repeated endpoints; the goal is out of reach here.
  task automatic test_edge_extremes();
    send_edge(10'd0, 10'd1023, weight_now);
    send_edge(10'd1023, 10'd0, weight_now);
    send_edge(10'd5, 10'd5, next_weight());
    send_edge(10'd1023, 10'd1023, next_weight());
    send_edge(10'd0, 10'd0, next_weight());
    send_edge(10'd6, 10'd5, next_weight());
    drain();
  endtask

  // A long parent chain, then a walk from its far end that compresses it.
  task automatic test_chain_compression();
    set_goal(GOAL_W'(NODES));
    for (int k = 100; k < 112; k++) send_edge(ID_W'(k + 1), ID_W'(k), next_weight());
    send_edge(10'd100, 10'd300, next_weight());
    send_edge(10'd300, 10'd101, next_weight());
    send_edge(10'd112, 10'd100, next_weight());
    send_edge(10'd1023, 10'd111, next_weight());
    drain();
  endtask

  // Mostly chain runs with random content, plus random, nearby, self and extreme edges.
  task automatic test_random_edges(input int n_items, input bit calm);
    int sent;
    int kind;
    int len;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
    logic [ID_W-1:0] last;
    sender_calm = calm;
    receiver_calm = calm;
    sent = 0;
    last = ID_W'($urandom);
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = $urandom_range(3, 12);
        a = ID_W'($urandom);
        for (int k = 0; k < len; k++) begin
          send_edge(a + 1'b1, a, next_weight());
          a = a + 1'b1;
        end
        sent += len;
      end else begin
        if (kind < 70) begin
          a = ID_W'($urandom);
          b = ID_W'($urandom);
        end else if (kind < 85) begin
          a = last;
          b = last + ID_W'($urandom_range(0, 3));
        end else if (kind < 90) begin
          a = ID_W'($urandom);
          b = a;
        end else begin
          a = $urandom_range(0, 1) ? '1 : '0;
          b = $urandom_range(0, 1) ? ID_W'($urandom) : ~a;
        end
        send_edge(a, b, next_weight());
        sent++;
      end
      last = a;
      if ($urandom_range(0, 199) == 0) drain();
    end
    drain();
  endtask

  // The goal flag fires once per reset: zero (hit on the next edge) or a mid-size target.
  task automatic test_goal_reach();
    if ($urandom_range(0, 3) == 0) set_goal('0);
    else set_goal(GOAL_W'($urandom_range(2, 600)));
    test_random_edges(900, 1'b0);
  endtask

  // Goal of one after it was already reached: flag must stay low; no idling either side.
  task automatic test_goal_one_shot();
    set_goal(GOAL_W'(1));
    test_random_edges(500, 1'b1);
  endtask

  task automatic test_goal_ceiling();
    set_goal(GOAL_W'(NODES));
    test_random_edges(500, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      forest_parent[i] = ID_W'(i);
      forest_size[i] = 1;
    end
    goal_reached = 1'b0;
    goal_cfg = GOAL_RESET;
    miss_count = 0;
    weight_now = '0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_config_extremes();
    test_edge_extremes();
    test_chain_compression();
    test_goal_reach();
    test_goal_one_shot();
    test_goal_ceiling();

    // let any stray late item show up before the verdict
    repeat (40) @(posedge clk);
    if (miss_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
